@@ hw/rtl/radio_telegram_packet_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Radio telegram packet parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIO_TELEGRAM_PACKET_PARSER_DEFINES_SVH
`define RADIO_TELEGRAM_PACKET_PARSER_DEFINES_SVH

// check cons in the same cycle as ante
`define RTPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define RTPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rtpp_pkg.sv @@
// ----------------------------------------------------------------------------
// Radio telegram packet parser package
// Telegram type codes, address control codes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpp_pkg;

    localparam logic [3:0] TYPE_RPS = 4'h0;
    localparam logic [3:0] TYPE_1BS = 4'h1;
    localparam logic [3:0] TYPE_4BS = 4'h2;
    localparam logic [3:0] TYPE_VLD = 4'h4;
    localparam logic [3:0] TYPE_EXT = 4'hF;

    localparam logic [2:0] AC_ID24   = 3'h0;
    localparam logic [2:0] AC_ID32_D = 3'h2;
    localparam logic [2:0] AC_ID48   = 3'h3;

    localparam logic [7:0] SYNC_RESET = 8'h55;

endpackage

`default_nettype wire

@@ hw/rtl/radio_telegram_packet_parser.sv @@
// ----------------------------------------------------------------------------
// Radio telegram packet parser
// Hunts for the sync byte, walks the serial packet header and radio telegram,
// and emits type, sender id, payload and signal level per kept telegram.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  input   | in_valid / in_stall    | rx_byte
//  output  | out_valid / out_stall  | telegram_type, sender_id, payload_word,
//          |                        | payload_bytes, rssi_dbm
//  config  | cfg_we                 | cfg_wdata (sync value)
//
//  One byte per cycle unless stalled; each byte is one parse state transition.
//  The output register takes a result in the cycle after the final byte.
//  in_stall is high only while the final byte is due and a result waits stalled.
//  Reset returns to sync hunt with all stores cleared; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radio_telegram_packet_parser_defines.svh"

module radio_telegram_packet_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       telegram_type,
    output logic [31:0]      sender_id,
    output logic [31:0]      payload_word,
    output logic [2:0]       payload_bytes,
    output logic [7:0]       rssi_dbm
);

    typedef enum logic [4:0] {
        ST_SYNC, ST_LEN_HI, ST_LEN_LO, ST_OPT_LEN, ST_PKT_TYPE, ST_HDR_CRC,
        ST_HEADER, ST_EXT_HDR, ST_EXT_TYPE,
        ST_ID_1, ST_ID_2, ST_ID_3, ST_ID_4, ST_ID_5, ST_ID_6,
        ST_DST_1, ST_DST_2, ST_DST_3, ST_DST_4,
        ST_PAY_1, ST_PAY_2, ST_PAY_3, ST_PAY_4,
        ST_OPTIONAL, ST_CRC, ST_SUBTEL, ST_DBM, ST_FINAL
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  sync_reg;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [7:0]  ext_reg, ext_next;
    logic [3:0]  opt_reg, opt_next;
    logic [31:0] sender_reg, sender_next;
    logic [31:0] payload_reg, payload_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  signal_reg, signal_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_type_reg, out_type_next;
    logic [31:0] out_sender_reg, out_sender_next;
    logic [31:0] out_payload_reg, out_payload_next;
    logic [2:0]  out_count_reg, out_count_next;
    logic [7:0]  out_rssi_reg, out_rssi_next;

    logic        accept;
    logic [3:0]  kind;
    logic        in_len_span;
    logic [15:0] rem_dec;
    logic [3:0]  opt_sel;
    logic [3:0]  opt_dec;
    logic        vld_end;
    state_t      end_state;

    function automatic state_t id_start(input logic [7:0] hb);
        priority if (hb[7:5] == rtpp_pkg::AC_ID24) return ST_ID_4;
        else if (hb[7:5] == rtpp_pkg::AC_ID48)     return ST_ID_1;
        else                                       return ST_ID_3;
    endfunction

    assign in_stall = out_valid_reg && out_stall && (state_reg == ST_FINAL);
    assign accept   = in_valid && !in_stall;

    assign kind        = hdr_reg[3:0];
    assign in_len_span = (state_reg >= ST_HEADER) && (state_reg <= ST_PAY_4);
    assign rem_dec     = in_len_span ? (rem_reg - 16'd1) : rem_reg;
    assign opt_sel     = (state_reg == ST_PAY_1) ? ext_reg[3:0] : opt_reg;
    assign opt_dec     = opt_reg - 4'd1;
    assign vld_end     = (kind == rtpp_pkg::TYPE_VLD)
                         && (rem_dec == ({12'd0, opt_sel} + 16'd1));
    assign end_state   = (opt_sel != 4'd0) ? ST_OPTIONAL : ST_CRC;

    always_comb
    begin
        state_next       = state_reg;
        len_hi_next      = len_hi_reg;
        rem_next         = rem_reg;
        hdr_next         = hdr_reg;
        ext_next         = ext_reg;
        opt_next         = opt_reg;
        sender_next      = sender_reg;
        payload_next     = payload_reg;
        count_next       = count_reg;
        signal_next      = signal_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_type_next    = out_type_reg;
        out_sender_next  = out_sender_reg;
        out_payload_next = out_payload_reg;
        out_count_next   = out_count_reg;
        out_rssi_next    = out_rssi_reg;

        if (accept)
        begin
            rem_next = rem_dec;
            unique case (state_reg)
                ST_SYNC:
                begin
                    state_next = (rx_byte == sync_reg) ? ST_LEN_HI : ST_SYNC;
                end
                ST_LEN_HI:
                begin
                    len_hi_next = rx_byte;
                    state_next  = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    rem_next   = {len_hi_reg, rx_byte};
                    state_next = ST_OPT_LEN;
                end
                ST_OPT_LEN:  state_next = ST_PKT_TYPE;
                ST_PKT_TYPE: state_next = ST_HDR_CRC;
                ST_HDR_CRC:  state_next = ST_HEADER;
                ST_HEADER:
                begin
                    hdr_next = rx_byte;
                    priority if (rx_byte[4])                      state_next = ST_EXT_HDR;
                    else if (rx_byte[3:0] == rtpp_pkg::TYPE_EXT)  state_next = ST_EXT_TYPE;
                    else                                          state_next = id_start(rx_byte);
                end
                ST_EXT_HDR:
                begin
                    ext_next   = rx_byte;
                    state_next = (kind == rtpp_pkg::TYPE_EXT) ? ST_EXT_TYPE : id_start(hdr_reg);
                end
                ST_EXT_TYPE: state_next = id_start(hdr_reg);
                ST_ID_1:     state_next = ST_ID_2;
                ST_ID_2:     state_next = ST_ID_3;
                ST_ID_3:
                begin
                    sender_next[31:24] = rx_byte;
                    state_next         = ST_ID_4;
                end
                ST_ID_4:
                begin
                    sender_next[23:16] = rx_byte;
                    state_next         = ST_ID_5;
                end
                ST_ID_5:
                begin
                    sender_next[15:8] = rx_byte;
                    state_next        = ST_ID_6;
                end
                ST_ID_6:
                begin
                    sender_next[7:0] = rx_byte;
                    state_next = (hdr_reg[7:5] == rtpp_pkg::AC_ID32_D) ? ST_DST_1 : ST_PAY_1;
                end
                ST_DST_1: state_next = ST_DST_2;
                ST_DST_2: state_next = ST_DST_3;
                ST_DST_3: state_next = ST_DST_4;
                ST_DST_4: state_next = ST_PAY_1;
                ST_PAY_1:
                begin
                    payload_next[31:24] = rx_byte;
                    opt_next            = opt_sel;
                    if (kind == rtpp_pkg::TYPE_RPS || kind == rtpp_pkg::TYPE_1BS || vld_end)
                    begin
                        count_next = 3'd1;
                        state_next = end_state;
                    end
                    else
                    begin
                        state_next = ST_PAY_2;
                    end
                end
                ST_PAY_2:
                begin
                    payload_next[23:16] = rx_byte;
                    if (vld_end)
                    begin
                        count_next = 3'd2;
                        state_next = end_state;
                    end
                    else
                    begin
                        state_next = ST_PAY_3;
                    end
                end
                ST_PAY_3:
                begin
                    payload_next[15:8] = rx_byte;
                    if (vld_end)
                    begin
                        count_next = 3'd3;
                        state_next = end_state;
                    end
                    else
                    begin
                        state_next = ST_PAY_4;
                    end
                end
                ST_PAY_4:
                begin
                    if (kind == rtpp_pkg::TYPE_4BS || vld_end)
                    begin
                        payload_next[7:0] = rx_byte;
                        count_next        = 3'd4;
                        state_next        = end_state;
                    end
                    else
                    begin
                        // drop the telegram
                        ext_next     = 8'd0;
                        sender_next  = 32'd0;
                        payload_next = 32'd0;
                        count_next   = 3'd0;
                        signal_next  = 8'd0;
                        state_next   = ST_SYNC;
                    end
                end
                ST_OPTIONAL:
                begin
                    opt_next   = opt_dec;
                    state_next = (opt_dec != 4'd0) ? ST_OPTIONAL : ST_CRC;
                end
                ST_CRC:    state_next = ST_SUBTEL;
                ST_SUBTEL: state_next = ST_DBM;
                ST_DBM:
                begin
                    signal_next = rx_byte;
                    state_next  = ST_FINAL;
                end
                ST_FINAL:
                begin
                    out_valid_next   = 1'b1;
                    out_type_next    = kind;
                    out_sender_next  = sender_reg;
                    out_payload_next = payload_reg;
                    out_count_next   = count_reg;
                    out_rssi_next    = signal_reg;
                    ext_next         = 8'd0;
                    sender_next      = 32'd0;
                    payload_next     = 32'd0;
                    count_next       = 3'd0;
                    signal_next      = 8'd0;
                    state_next       = ST_SYNC;
                end
                default:
                begin
                    state_next = ST_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SYNC;
            sync_reg        <= rtpp_pkg::SYNC_RESET;
            len_hi_reg      <= 8'd0;
            rem_reg         <= 16'd0;
            hdr_reg         <= 8'd0;
            ext_reg         <= 8'd0;
            opt_reg         <= 4'd0;
            sender_reg      <= 32'd0;
            payload_reg     <= 32'd0;
            count_reg       <= 3'd0;
            signal_reg      <= 8'd0;
            out_valid_reg   <= 1'b0;
            out_type_reg    <= 4'd0;
            out_sender_reg  <= 32'd0;
            out_payload_reg <= 32'd0;
            out_count_reg   <= 3'd0;
            out_rssi_reg    <= 8'd0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                sync_reg <= cfg_wdata;
            end
            len_hi_reg      <= len_hi_next;
            rem_reg         <= rem_next;
            hdr_reg         <= hdr_next;
            ext_reg         <= ext_next;
            opt_reg         <= opt_next;
            sender_reg      <= sender_next;
            payload_reg     <= payload_next;
            count_reg       <= count_next;
            signal_reg      <= signal_next;
            out_valid_reg   <= out_valid_next;
            out_type_reg    <= out_type_next;
            out_sender_reg  <= out_sender_next;
            out_payload_reg <= out_payload_next;
            out_count_reg   <= out_count_next;
            out_rssi_reg    <= out_rssi_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign telegram_type = out_type_reg;
    assign sender_id     = out_sender_reg;
    assign payload_word  = out_payload_reg;
    assign payload_bytes = out_count_reg;
    assign rssi_dbm      = out_rssi_reg;

    `RTPP_ASSERT_NEXT(a_final_emits, accept && (state_reg == ST_FINAL),
        out_valid_reg && (state_reg == ST_SYNC), "final byte did not emit a transaction")
    `RTPP_ASSERT_NEXT(a_final_clears, accept && (state_reg == ST_FINAL),
        (sender_reg == 32'd0) && (payload_reg == 32'd0) && (count_reg == 3'd0),
        "stores not cleared after final byte")
    `RTPP_ASSERT_NOW(a_count_range, out_valid_reg,
        (out_count_reg != 3'd0) && (out_count_reg <= 3'd4), "payload byte count out of range")
    `RTPP_ASSERT_NOW(a_opt_nonzero, state_reg == ST_OPTIONAL,
        opt_reg != 4'd0, "optional byte count is zero in optional state")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio telegram packet parser testbench
// Streams serial-link bytes into the parser: framed telegrams of every type,
// address-control mode and extended-header shape, plus noise and broken
// frames. A byte-level tracker follows each accepted transaction and queues
// the telegram it should produce, and each output transaction is checked field
// by field against it. Both handshakes idle at random. The sync value is
// rewritten between phases while the parser is drained.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum logic [4:0] {
        P_HUNT, P_LEN_HI, P_LEN_LO, P_OPT_LEN, P_PKT_TYPE, P_HDR_CRC,
        P_HEADER, P_EXT_HDR, P_EXT_TYPE,
        P_ID_1, P_ID_2, P_ID_3, P_ID_4, P_ID_5, P_ID_6,
        P_DST_1, P_DST_2, P_DST_3, P_DST_4,
        P_PAY_1, P_PAY_2, P_PAY_3, P_PAY_4,
        P_OPTIONAL, P_CRC, P_SUBTEL, P_DBM, P_FINAL
    } parse_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] sender;
        logic [31:0] data;
        logic [2:0]  count;
        logic [7:0]  rssi;
    } telegram_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  telegram_type;
    logic [31:0] sender_id;
    logic [31:0] payload_word;
    logic [2:0]  payload_bytes;
    logic [7:0]  rssi_dbm;

    logic [7:0]  byte_backlog[$];
    telegram_t   telegrams_due[$];
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          errors = 0;
    int          gap_pct = 38;
    int          stall_pct = 38;
    logic [7:0]  sync_cur = rtpp_pkg::SYNC_RESET;

    parse_t      walk_state = P_HUNT;
    logic [7:0]  p_sync = rtpp_pkg::SYNC_RESET;
    logic [7:0]  p_len_hi = 8'h00;
    logic [15:0] p_rem = 16'h0000;
    logic [7:0]  p_hdr = 8'h00;
    logic [7:0]  p_ext = 8'h00;
    logic [3:0]  p_opt = 4'h0;
    logic [31:0] p_sender = 32'h0;
    logic [31:0] p_data = 32'h0;
    logic [2:0]  p_count = 3'd0;
    logic [7:0]  p_rssi = 8'h00;

    radio_telegram_packet_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .telegram_type(telegram_type),
        .sender_id(sender_id),
        .payload_word(payload_word),
        .payload_bytes(payload_bytes),
        .rssi_dbm(rssi_dbm)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic parse_t id_entry(input logic [2:0] ac);
        if (ac == rtpp_pkg::AC_ID24)
            return P_ID_4;
        if (ac == rtpp_pkg::AC_ID48)
            return P_ID_1;
        return P_ID_3;
    endfunction

    function automatic bit vld_end();
        return (p_hdr[3:0] == rtpp_pkg::TYPE_VLD) && (p_rem == 16'(p_opt) + 16'd1);
    endfunction

    function automatic parse_t payload_exit();
        return (p_opt != 4'h0) ? P_OPTIONAL : P_CRC;
    endfunction

    task automatic clear_stores();
        p_ext = 8'h00;
        p_sender = 32'h0;
        p_data = 32'h0;
        p_count = 3'd0;
        p_rssi = 8'h00;
    endtask

    task automatic track_byte(input logic [7:0] b);
        logic [3:0] kind;
        logic [2:0] ac;
        parse_t     nxt;
        telegram_t  t;
        kind = p_hdr[3:0];
        ac = p_hdr[7:5];
        nxt = P_HUNT;
        if (walk_state >= P_HEADER && walk_state <= P_PAY_4)
            p_rem = p_rem - 16'd1;
        case (walk_state)
            P_HUNT:     nxt = (b == p_sync) ? P_LEN_HI : P_HUNT;
            P_LEN_HI:
            begin
                p_len_hi = b;
                nxt = P_LEN_LO;
            end
            P_LEN_LO:
            begin
                p_rem = {p_len_hi, b};
                nxt = P_OPT_LEN;
            end
            P_OPT_LEN:  nxt = P_PKT_TYPE;
            P_PKT_TYPE: nxt = P_HDR_CRC;
            P_HDR_CRC:  nxt = P_HEADER;
            P_HEADER:
            begin
                p_hdr = b;
                if (b[4])
                    nxt = P_EXT_HDR;
                else if (b[3:0] == rtpp_pkg::TYPE_EXT)
                    nxt = P_EXT_TYPE;
                else
                    nxt = id_entry(b[7:5]);
            end
            P_EXT_HDR:
            begin
                p_ext = b;
                nxt = (kind == rtpp_pkg::TYPE_EXT) ? P_EXT_TYPE : id_entry(ac);
            end
            P_EXT_TYPE: nxt = id_entry(ac);
            P_ID_1:     nxt = P_ID_2;
            P_ID_2:     nxt = P_ID_3;
            P_ID_3:
            begin
                p_sender[31:24] = b;
                nxt = P_ID_4;
            end
            P_ID_4:
            begin
                p_sender[23:16] = b;
                nxt = P_ID_5;
            end
            P_ID_5:
            begin
                p_sender[15:8] = b;
                nxt = P_ID_6;
            end
            P_ID_6:
            begin
                p_sender[7:0] = b;
                nxt = (ac == rtpp_pkg::AC_ID32_D) ? P_DST_1 : P_PAY_1;
            end
            P_DST_1:    nxt = P_DST_2;
            P_DST_2:    nxt = P_DST_3;
            P_DST_3:    nxt = P_DST_4;
            P_DST_4:    nxt = P_PAY_1;
            P_PAY_1:
            begin
                p_data[31:24] = b;
                p_opt = p_ext[3:0];
                if (kind == rtpp_pkg::TYPE_RPS || kind == rtpp_pkg::TYPE_1BS || vld_end())
                begin
                    p_count = 3'd1;
                    nxt = payload_exit();
                end
                else
                    nxt = P_PAY_2;
            end
            P_PAY_2:
            begin
                p_data[23:16] = b;
                if (vld_end())
                begin
                    p_count = 3'd2;
                    nxt = payload_exit();
                end
                else
                    nxt = P_PAY_3;
            end
            P_PAY_3:
            begin
                p_data[15:8] = b;
                if (vld_end())
                begin
                    p_count = 3'd3;
                    nxt = payload_exit();
                end
                else
                    nxt = P_PAY_4;
            end
            P_PAY_4:
            begin
                p_data[7:0] = b;
                if (kind == rtpp_pkg::TYPE_4BS || vld_end())
                begin
                    p_count = 3'd4;
                    nxt = payload_exit();
                end
                else
                begin
                    clear_stores();
                    nxt = P_HUNT;
                end
            end
            P_OPTIONAL:
            begin
                p_opt = p_opt - 4'h1;
                nxt = (p_opt != 4'h0) ? P_OPTIONAL : P_CRC;
            end
            P_CRC:      nxt = P_SUBTEL;
            P_SUBTEL:   nxt = P_DBM;
            P_DBM:
            begin
                p_rssi = b;
                nxt = P_FINAL;
            end
            P_FINAL:
            begin
                t.kind = kind;
                t.sender = p_sender;
                t.data = p_data;
                t.count = p_count;
                t.rssi = p_rssi;
                telegrams_due.push_back(t);
                clear_stores();
                nxt = P_HUNT;
            end
            default:    nxt = P_HUNT;
        endcase
        walk_state = nxt;
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
        end
        else if (!in_valid || !in_stall)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= byte_backlog.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        telegram_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (telegrams_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected telegram, expected none, actual type %0h id %0h",
                             $time, telegram_type, sender_id);
                end
                else
                begin
                    due = telegrams_due.pop_front();
                    check_field("telegram_type", 32'(due.kind), 32'(telegram_type));
                    check_field("sender_id", due.sender, sender_id);
                    check_field("payload_word", due.data, payload_word);
                    check_field("payload_bytes", 32'(due.count), 32'(payload_bytes));
                    check_field("rssi_dbm", 32'(due.rssi), 32'(rssi_dbm));
                end
            end
            if (in_valid && !in_stall)
            begin
                track_byte(rx_byte);
                bytes_taken++;
            end
            if (cfg_we)
                p_sync = cfg_wdata;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    // len_sel below zero: fit the data length so a VLD payload ends on vld_n bytes
    task automatic queue_telegram(input logic [7:0] hdr, input logic [7:0] ext,
                                  input int vld_n, input int len_sel);
        logic [3:0]  kind;
        logic [2:0]  ac;
        logic [15:0] len;
        int          opt;
        int          id_n;
        int          pay_n;
        int          pre;
        bit          kept;
        kind = hdr[3:0];
        ac = hdr[7:5];
        opt = hdr[4] ? int'(ext[3:0]) : 0;
        id_n = (ac == rtpp_pkg::AC_ID24) ? 3 : (ac == rtpp_pkg::AC_ID48) ? 6 : 4;
        if (ac == rtpp_pkg::AC_ID32_D)
            id_n += 4;
        pre = 1 + int'(hdr[4]) + int'(kind == rtpp_pkg::TYPE_EXT) + id_n;
        if (kind == rtpp_pkg::TYPE_RPS || kind == rtpp_pkg::TYPE_1BS)
            pay_n = 1;
        else if (kind == rtpp_pkg::TYPE_VLD)
            pay_n = vld_n;
        else
            pay_n = 4;
        len = (len_sel < 0) ? 16'(pre + pay_n + opt + 1) : 16'(len_sel);
        kept = (kind == rtpp_pkg::TYPE_RPS || kind == rtpp_pkg::TYPE_1BS ||
                kind == rtpp_pkg::TYPE_4BS) ||
               (kind == rtpp_pkg::TYPE_VLD && len_sel < 0);
        push_byte(sync_cur);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_random(3);
        push_byte(hdr);
        if (hdr[4])
            push_byte(ext);
        if (kind == rtpp_pkg::TYPE_EXT)
            push_random(1);
        push_random(id_n + pay_n);
        if (kept)
            push_random(opt + 4);
    endtask

    task automatic random_telegram();
        logic [3:0] kind;
        logic [7:0] hdr;
        logic [7:0] ext;
        int         pick;
        int         len_sel;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            kind = rtpp_pkg::TYPE_RPS;
        else if (pick == 2)
            kind = rtpp_pkg::TYPE_1BS;
        else if (pick < 5)
            kind = rtpp_pkg::TYPE_4BS;
        else if (pick < 8)
            kind = rtpp_pkg::TYPE_VLD;
        else if (pick == 8)
            kind = rtpp_pkg::TYPE_EXT;
        else
            kind = 4'($urandom_range(0, 15));
        hdr = {3'($urandom_range(0, 7)), ($urandom_range(0, 2) == 0), kind};
        ext[7:4] = 4'($urandom_range(0, 15));
        ext[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
        if (kind != rtpp_pkg::TYPE_VLD || $urandom_range(0, 9) == 0)
            len_sel = $urandom_range(0, 65535);
        else
            len_sel = -1;
        queue_telegram(hdr, ext, $urandom_range(1, 4), len_sel);
    endtask

    task automatic random_phase(input int nbytes);
        int start;
        int n;
        start = bytes_queued;
        while (bytes_queued - start < nbytes)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 6);
                push_byte(($urandom_range(0, 1) == 0) ? sync_cur
                                                      : 8'($urandom_range(0, 255)));
                push_random(n - 1);
            end
            else
                random_telegram();
        end
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (telegrams_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sync_cur = v;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_telegram({rtpp_pkg::AC_ID24, 1'b0, rtpp_pkg::TYPE_RPS}, 8'h00, 1, -1);
        queue_telegram({rtpp_pkg::AC_ID48, 1'b0, rtpp_pkg::TYPE_1BS}, 8'h00, 1, -1);
        queue_telegram({rtpp_pkg::AC_ID32_D, 1'b0, rtpp_pkg::TYPE_4BS}, 8'h00, 4, -1);
        queue_telegram({3'($urandom_range(4, 7)), 1'b1, rtpp_pkg::TYPE_VLD}, 8'hF0, 1, -1);
        queue_telegram({rtpp_pkg::AC_ID48, 1'b1, rtpp_pkg::TYPE_VLD}, 8'h02, 3, -1);
        queue_telegram({rtpp_pkg::AC_ID32_D, 1'b1, rtpp_pkg::TYPE_VLD}, 8'h0F, 4, -1);
        queue_telegram({rtpp_pkg::AC_ID24, 1'b0, rtpp_pkg::TYPE_VLD}, 8'h00, 2, -1);
        queue_telegram({rtpp_pkg::AC_ID24, 1'b1, rtpp_pkg::TYPE_EXT}, 8'h01, 4, -1);
        queue_telegram({rtpp_pkg::AC_ID48, 1'b0, rtpp_pkg::TYPE_EXT}, 8'h00, 4, -1);
        queue_telegram({3'($urandom_range(4, 7)), 1'b0, 4'($urandom_range(5, 14))},
                       8'h00, 4, -1);
        queue_telegram({rtpp_pkg::AC_ID32_D, 1'b0, rtpp_pkg::TYPE_VLD}, 8'h00, 4, 0);
        queue_telegram({rtpp_pkg::AC_ID24, 1'b0, rtpp_pkg::TYPE_RPS}, 8'h00, 1, -1);
        drain();

        write_sync(8'hFF);
        queue_telegram({rtpp_pkg::AC_ID24, 1'b1, rtpp_pkg::TYPE_4BS}, 8'hFF, 4, 16'hFFFF);
        random_phase(30);
        drain();

        write_sync(8'h00);
        random_phase(60);
        drain();

        // no input gaps and no output stalls for a whole phase
        gap_pct = 0;
        stall_pct = 0;
        write_sync(rtpp_pkg::SYNC_RESET);
        random_phase(90);
        drain();
        gap_pct = 38;
        stall_pct = 38;

        repeat (3)
        begin
            write_sync(8'($urandom_range(0, 255)));
            random_phase(60);
            drain();
        end

        write_sync(8'hFF);
        random_phase(40);
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
